// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the gradient map RTL.
// No dependencies; compile out with ASSERT_OFF.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/gmp_pkg.sv =====
// Types and constants of the gradient map pixel core.
// No dependencies.
package gmp_pkg;
    localparam int MAX_STOPS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int NUM_W = 24;
    localparam int DV_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_INPUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE = 3'd2;

    localparam logic [12:0] W_RED = 13'd4899;
    localparam logic [13:0] W_GREEN = 14'd9617;
    localparam logic [10:0] W_BLUE = 11'd1868;
    localparam logic [21:0] GRAY_ROUND = 22'd8192;

    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_stop;

    typedef struct packed {
        logic [2:0]                 stop_count;
        logic                       color_input;
        t_stop [MAX_STOPS-1:0]      stops;
    } t_cfg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    // channel 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][7:0] c0;
        logic [2:0][7:0] c1;
        logic [15:0]     len;
        logic [15:0]     d;
    } t_seg;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][7:0]       q;
        logic [DV_W-1:0]       dv;
    } t_div;
endpackage

// ===== rtl/gmp_gray.sv =====
// Gray stage: BT.601 reduction or pass-through of the blue channel.
// Depends on gmp_pkg.
module gmp_gray (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  gmp_pkg::t_pix i_pix,
    input  logic          i_color,
    output logic          o_valid,
    output logic [7:0]    o_gray
);
    import gmp_pkg::*;

    logic [21:0] n_sum;
    logic        r_valid;
    logic [7:0]  r_gray;

    always_comb begin
        n_sum = 22'(W_RED * i_pix.red) + 22'(W_GREEN * i_pix.green)
              + 22'(W_BLUE * i_pix.blue) + GRAY_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_gray <= i_color ? n_sum[21:14] : i_pix.blue;
        end
    end

    assign o_valid = r_valid;
    assign o_gray  = r_gray;
endmodule

// ===== rtl/gmp_select.sv =====
// Segment stage: clamp tests and first holding segment, end colours and offsets.
// Depends on gmp_pkg.
module gmp_select (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  logic [7:0]    i_gray,
    input  gmp_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output gmp_pkg::t_seg o_seg
);
    import gmp_pkg::*;

    logic [2:0]  n_cnt;
    logic [2:0]  n_last;
    logic [15:0] n_t;
    logic        n_found;
    t_seg        n_seg;
    t_stop       n_a;
    t_stop       n_b;
    logic        r_valid;
    t_seg        r_seg;

    always_comb begin
        n_cnt = i_cfg.stop_count;
        if (n_cnt < 3'd2) n_cnt = 3'd2;
        if (n_cnt > 3'(MAX_STOPS)) n_cnt = 3'(MAX_STOPS);
        n_last = n_cnt - 3'd1;
        n_t = {i_gray, 8'h00};
        n_found = 1'b0;
        n_a = '0;
        n_b = '0;
        n_seg = '0;
        n_seg.len = 16'd1;
        if (n_t <= i_cfg.stops[0].pos) begin
            n_a = i_cfg.stops[0];
            n_b = i_cfg.stops[0];
        end else if (n_t >= i_cfg.stops[n_last].pos) begin
            n_a = i_cfg.stops[n_last];
            n_b = i_cfg.stops[n_last];
        end else begin
            for (int j = 0; j < MAX_STOPS - 1; j++) begin
                if (!n_found && (3'(j + 1) < n_cnt) && n_t >= i_cfg.stops[j].pos
                    && n_t <= i_cfg.stops[j+1].pos) begin
                    n_found = 1'b1;
                    n_a = i_cfg.stops[j];
                    n_b = i_cfg.stops[j+1];
                    n_seg.len = i_cfg.stops[j+1].pos - i_cfg.stops[j].pos;
                    n_seg.d = n_t - i_cfg.stops[j].pos;
                end
            end
            // zero length segment: weight 0, so the first colour
            if (n_seg.len == 16'd0) begin
                n_seg.len = 16'd1;
                n_seg.d = 16'd0;
            end
        end
        n_seg.c0 = {n_a.blue, n_a.green, n_a.red};
        n_seg.c1 = {n_b.blue, n_b.green, n_b.red};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_seg <= n_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

    `include "assert_macros.svh"
    `ASSERT_IMP(a_off_in_seg, i_clk, i_rst_n, r_valid, r_seg.d <= r_seg.len)
    `ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, r_valid, r_seg.len != 16'd0)
    `ASSERT_IMP(a_clamp_flat, i_clk, i_rst_n, r_valid && r_seg.d == 16'd0 && r_seg.len == 16'd1, r_seg.len == 16'd1)
endmodule

// ===== rtl/gmp_lerp.sv =====
// Weighting stage: numerator c0*(L-d) + c1*d per channel, divisor set-up.
// Depends on gmp_pkg.
module gmp_lerp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  gmp_pkg::t_seg i_seg,
    output logic          o_valid,
    output gmp_pkg::t_div o_div
);
    import gmp_pkg::*;

    logic [15:0] n_rest;
    t_div        n_div;
    logic        r_valid;
    t_div        r_div;

    always_comb begin
        n_rest = i_seg.len - i_seg.d;
        n_div.q = '0;
        n_div.dv = {i_seg.len, 7'd0};
        for (int c = 0; c < 3; c++) begin
            n_div.rem[c] = NUM_W'(i_seg.c0[c] * n_rest) + NUM_W'(i_seg.c1[c] * i_seg.d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule

// ===== rtl/gmp_div_step.sv =====
// Divider stage: two restoring quotient bits for all three channels.
// Depends on gmp_pkg.
module gmp_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  gmp_pkg::t_div i_div,
    output logic          o_valid,
    output gmp_pkg::t_div o_div
);
    import gmp_pkg::*;

    t_div n_div;
    logic r_valid;
    t_div r_div;

    always_comb begin
        n_div = i_div;
        for (int b = 0; b < 2; b++) begin
            for (int c = 0; c < 3; c++) begin
                if (n_div.rem[c] >= {1'b0, n_div.dv}) begin
                    n_div.rem[c] = n_div.rem[c] - {1'b0, n_div.dv};
                    n_div.q[c] = {n_div.q[c][6:0], 1'b1};
                end else begin
                    n_div.q[c] = {n_div.q[c][6:0], 1'b0};
                end
            end
            n_div.dv = n_div.dv >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
endmodule

// ===== rtl/gradient_map_pixel_core.sv =====
// Top level of the gradient map pixel core: config registers, stage chain.
// Depends on gmp_pkg, gmp_gray, gmp_select, gmp_lerp, gmp_div_step.
//
//  channel   valid     stall     payload
//  pixel in  i_valid   o_stall   i_in_blue, i_in_green, i_in_red
//  colour    o_valid   i_stall   o_out_blue, o_out_green, o_out_red
//  config    i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// One pixel per cycle unless stalled; stages: gray, segment, weighting,
// then four divider stages of two quotient bits (the last is the output).
// Reset clears the valid bits and loads the default ramp (black to white).
// Each stage holds while its successor is full and stalled; bubbles close
// up, so requests are taken while a result waits at the output.
module gradient_map_pixel_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_in_blue,
    input  logic [7:0]                      i_in_green,
    input  logic [7:0]                      i_in_red,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_blue,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_red,
    input  logic                            i_cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gmp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gmp_pkg::*;

    localparam int NSTG = 7;

    t_cfg            r_cfg;
    t_pix            n_pix;
    logic [NSTG-1:0] n_adv;
    logic [NSTG-1:0] n_v;
    logic [7:0]      n_gray;
    t_seg            n_seg;
    t_div [4:0]      n_div;

    // register file; of the stops only stop one resets to non-zero (white at 1.0)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_count  <= 3'd2;
            r_cfg.color_input <= 1'b1;
            r_cfg.stops       <= {{(MAX_STOPS-2){40'h0}}, 40'hFF00FFFFFF, 40'h0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STOP_COUNT:  r_cfg.stop_count <= i_cfg_data[2:0];
                REG_COLOR_INPUT: r_cfg.color_input <= i_cfg_data[0];
                default: r_cfg.stops[i_cfg_idx - REG_STOP_BASE] <= t_stop'(i_cfg_data);
            endcase
        end
    end

    // advance a stage when empty or when its successor advances
    always_comb begin
        n_adv[NSTG-1] = !n_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_adv[k] = !n_v[k] || n_adv[k+1];
        end
    end

    assign n_pix = '{blue: i_in_blue, green: i_in_green, red: i_in_red};
    assign o_stall = !n_adv[0];

    gmp_gray u_gray (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(n_adv[0]), .i_valid(i_valid),
        .i_pix(n_pix), .i_color(r_cfg.color_input), .o_valid(n_v[0]), .o_gray(n_gray)
    );

    gmp_select u_select (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(n_adv[1]), .i_valid(n_v[0]),
        .i_gray(n_gray), .i_cfg(r_cfg), .o_valid(n_v[1]), .o_seg(n_seg)
    );

    gmp_lerp u_lerp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(n_adv[2]), .i_valid(n_v[1]),
        .i_seg(n_seg), .o_valid(n_v[2]), .o_div(n_div[0])
    );

    for (genvar s = 0; s < 4; s++) begin : g_div
        gmp_div_step u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(n_adv[3+s]), .i_valid(n_v[2+s]),
            .i_div(n_div[s]), .o_valid(n_v[3+s]), .o_div(n_div[s+1])
        );
    end

    assign o_valid     = n_v[NSTG-1];
    assign o_out_red   = n_div[4].q[0];
    assign o_out_green = n_div[4].q[1];
    assign o_out_blue  = n_div[4].q[2];

    `include "assert_macros.svh"
    `ASSERT_IMP(a_idle_no_stall, i_clk, i_rst_n, !o_valid, !o_stall)
    `ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, (&n_v) && i_stall)
    `ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_red) && $stable(o_out_blue))
endmodule

// ===== tb/sv/gradient_map_pixel_core_test.sv =====
// Self-checking bench for gradient_map_pixel_core: pixels through colour ramps.
// Depends on gmp_pkg and the RTL of gradient_map_pixel_core; nothing else.
// A local ramp predictor checks every colour against its request, in order.
module gradient_map_pixel_core_test;
    import gmp_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_in_blue = '0;
    logic [7:0]            i_in_green = '0;
    logic [7:0]            i_in_red = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_out_blue;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_red;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // One directed request: pixel and, where obvious, the colour it must give.
    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        bit         typed;
        t_pix       colour;
    } t_pixel_row;

    t_cfg   ramp_cfg;           // shadow of the block's registers
    t_pix   colour_queue[$];    // colours still owed by the block
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_req = 1'b0;    // toggled to ask the receiver for a long hold-off
    bit     hold_seen = 1'b0;
    int     hold_left = 0;

    gradient_map_pixel_core u_top (.*);

    always #2 i_clk = ~i_clk;

    // Safety net far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("gradient_map_pixel_core: mismatch");
        $finish;
    end

    function automatic int blend(input int c0, input int c1, input int d, input int len);
        longint acc;
        if (len == 0) begin
            return c0;
        end
        acc = longint'(c0) * (len - d) + longint'(c1) * d;
        return int'(acc / len);
    endfunction

    // Predict the colour that the current ramp gives to one pixel.
    function automatic t_pix ramp_colour(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
        int    n;
        int    gray;
        int    t;
        int    p0;
        int    p1;
        t_stop s0;
        t_stop s1;
        t_pix  res;
        res = '0;
        n = int'(ramp_cfg.stop_count);
        if (n < 2) n = 2;
        if (n > MAX_STOPS) n = MAX_STOPS;
        if (ramp_cfg.color_input)
            gray = (4899 * int'(r) + 9617 * int'(g) + 1868 * int'(b) + 8192) >> 14;
        else
            gray = int'(b);
        t = gray << 8;
        s0 = ramp_cfg.stops[0];
        s1 = ramp_cfg.stops[n-1];
        if (t <= int'(s0.pos)) begin
            res.red = s0.red; res.green = s0.green; res.blue = s0.blue;
        end else if (t >= int'(s1.pos)) begin
            res.red = s1.red; res.green = s1.green; res.blue = s1.blue;
        end else begin
            // first segment holding t wins; none found leaves black
            for (int j = 0; j + 1 < n; j++) begin
                s0 = ramp_cfg.stops[j];
                s1 = ramp_cfg.stops[j+1];
                p0 = int'(s0.pos);
                p1 = int'(s1.pos);
                if (t >= p0 && t <= p1) begin
                    res.red   = 8'(blend(s0.red,   s1.red,   t - p0, p1 - p0));
                    res.green = 8'(blend(s0.green, s1.green, t - p0, p1 - p0));
                    res.blue  = 8'(blend(s0.blue,  s1.blue,  t - p0, p1 - p0));
                    break;
                end
            end
        end
        return res;
    endfunction

    // Offer one request; hold it until taken, then maybe idle the sender.
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input bit typed, input t_pix colour);
        i_valid    <= 1'b1;
        i_in_blue  <= b;
        i_in_green <= g;
        i_in_red   <= r;
        colour_queue.push_back(typed ? colour : ramp_colour(b, g, r));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // idle cycle by cycle with the sender's idle odds
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        t_pix none;
        none = '0;
        for (int k = 0; k < count; k++) begin
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0, none);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain the pipeline, then write every register in one burst.
    task automatic load_ramp(input t_cfg cfg);
        while (colour_queue.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        ramp_cfg = cfg;
        for (int k = 0; k < 2 + MAX_STOPS; k++) begin
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= k[CFG_IDX_W-1:0];
            if (k[CFG_IDX_W-1:0] == REG_STOP_COUNT)
                i_cfg_data <= CFG_DATA_W'(cfg.stop_count);
            else if (k[CFG_IDX_W-1:0] == REG_COLOR_INPUT)
                i_cfg_data <= CFG_DATA_W'(cfg.color_input);
            else
                i_cfg_data <= cfg.stops[k - REG_STOP_BASE];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Build a random ramp: mostly ascending, some equal positions, some disorder.
    function automatic t_cfg random_ramp();
        t_cfg cfg;
        int   pos[MAX_STOPS];
        int   tmp;
        cfg.stop_count  = 3'($urandom_range(0, 7));
        cfg.color_input = 1'($urandom_range(0, 1));
        for (int k = 0; k < MAX_STOPS; k++) begin
            case ($urandom_range(0, 9))
                0: pos[k] = 0;
                1: pos[k] = 65535;
                2: pos[k] = 65280;
                default: pos[k] = int'($urandom_range(0, 65535));
            endcase
        end
        if ($urandom_range(0, 4) != 0) begin
            for (int a = 0; a < MAX_STOPS; a++)
                for (int c = a + 1; c < MAX_STOPS; c++)
                    if (pos[c] < pos[a]) begin
                        tmp = pos[a]; pos[a] = pos[c]; pos[c] = tmp;
                    end
            if ($urandom_range(0, 2) == 0) pos[2] = pos[1];  // zero-length segment
        end
        for (int k = 0; k < MAX_STOPS; k++) begin
            cfg.stops[k].pos   = 16'(pos[k]);
            cfg.stops[k].red   = 8'($urandom_range(0, 255));
            cfg.stops[k].green = 8'($urandom_range(0, 255));
            cfg.stops[k].blue  = 8'($urandom_range(0, 255));
        end
        return cfg;
    endfunction

    // Receiver: check each colour taken, then choose the next stall.
    always @(posedge i_clk) begin
        t_pix want;
        if (o_valid && !i_stall) begin
            if (colour_queue.size() == 0) begin
                $display("%0t: unexpected colour b=%0d g=%0d r=%0d", $time,
                         o_out_blue, o_out_green, o_out_red);
                fail_count++;
            end else begin
                want = colour_queue.pop_front();
                if (o_out_blue !== want.blue || o_out_green !== want.green ||
                    o_out_red !== want.red) begin
                    $display("%0t: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                             $time, want.blue, want.green, want.red,
                             o_out_blue, o_out_green, o_out_red);
                    fail_count++;
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin
        t_pixel_row rows[$];
        t_cfg       cfg;
        int         wait_cycles;

        // reset ramp: black at 0, white at 1.0, colour input
        ramp_cfg = '0;
        ramp_cfg.stop_count = 3'd2;
        ramp_cfg.color_input = 1'b1;
        ramp_cfg.stops[1] = 40'hFF00FFFFFF;

        rows = '{
            '{8'h00, 8'h00, 8'h00, 1'b1, '{8'd0,   8'd0,   8'd0}},
            '{8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
            '{8'h00, 8'h00, 8'hFF, 1'b1, '{8'd76,  8'd76,  8'd76}},
            '{8'h00, 8'hFF, 8'h00, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'hFF, 8'h00, 8'h00, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'hAA, 8'h55, 8'hAA, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'h55, 8'hAA, 8'h55, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'h80, 8'h80, 8'h7F, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{8'h01, 8'h01, 8'h01, 1'b0, '{8'd0,   8'd0,   8'd0}}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_pixel(rows[k].blue, rows[k].green, rows[k].red, rows[k].typed,
                       rows[k].colour);
        i_valid <= 1'b0;
        @(posedge i_clk);

        // extremes: all six stops, gray input, edge positions and colours
        cfg = '0;
        cfg.stop_count = 3'd6;
        cfg.stops[0] = {16'd0,     24'hFF00FF};
        cfg.stops[1] = {16'd0,     24'h00FF00};
        cfg.stops[2] = {16'd256,   24'hFFFFFF};
        cfg.stops[3] = {16'd32768, 24'h000000};
        cfg.stops[4] = {16'd65280, 24'hFFFFFF};
        cfg.stops[5] = {16'd65535, 24'h123456};
        load_ramp(cfg);
        foreach (rows[k])
            send_pixel(rows[k].blue, rows[k].green, rows[k].red, 1'b0, '0);
        for (int k = 0; k < 4; k++)
            send_pixel(8'(k * 85), 8'h00, 8'h00, 1'b0, '0);
        i_valid <= 1'b0;
        @(posedge i_clk);

        // three idling regimes, several random ramps each
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 83 : 0;
            recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 29 : 0;
            for (int ph = 0; ph < 6; ph++) begin
                load_ramp(random_ramp());
                if (mode == 2 && ph == 0) begin
                    // long hold-off at the output while requests keep coming
                    hold_req <= ~hold_req;
                    @(posedge i_clk);
                end
                send_random(48);
            end
        end

        wait_cycles = 0;
        while (colour_queue.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && colour_queue.size() == 0) begin
            $display("gradient_map_pixel_core: match");
        end else begin
            $display("gradient_map_pixel_core: mismatch");
        end
        $finish;
    end
endmodule

// ===== gradient_map_pixel_core.f =====
+incdir+rtl
rtl/gmp_pkg.sv
rtl/gmp_gray.sv
rtl/gmp_select.sv
rtl/gmp_lerp.sv
rtl/gmp_div_step.sv
rtl/gradient_map_pixel_core.sv
tb/sv/gradient_map_pixel_core_test.sv
